FILE: hdl/accumulator_alu_with_flags_macros.svh
// assertion macros for the accumulator alu block
// used by accumulator_alu_with_flags.sv; expects clk and rst_n in scope
`ifndef ACCUMULATOR_ALU_WITH_FLAGS_MACROS_SVH
`define ACCUMULATOR_ALU_WITH_FLAGS_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, disabled in reset
`define AAWF_ASSERT_IMP(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("accumulator alu: same-cycle check failed");
// next-cycle implication, disabled in reset
`define AAWF_ASSERT_NXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("accumulator alu: next-cycle check failed");
`else
`define AAWF_ASSERT_IMP(lbl, ant, cons)
`define AAWF_ASSERT_NXT(lbl, ant, cons)
`endif
`endif

FILE: hdl/aawf_pkg.sv
// types and opcode constants for the accumulator alu
// no dependencies
`default_nettype none
package aawf_pkg;

  localparam int unsigned OP_W   = 5;
  localparam int unsigned DATA_W = 8;

  // opcodes
  localparam logic [OP_W-1:0] OP_ADD  = 5'd0;
  localparam logic [OP_W-1:0] OP_ADC  = 5'd1;
  localparam logic [OP_W-1:0] OP_SUB  = 5'd2;
  localparam logic [OP_W-1:0] OP_SBB  = 5'd3;
  localparam logic [OP_W-1:0] OP_AND  = 5'd4;
  localparam logic [OP_W-1:0] OP_XOR  = 5'd5;
  localparam logic [OP_W-1:0] OP_OR   = 5'd6;
  localparam logic [OP_W-1:0] OP_CMP  = 5'd7;
  localparam logic [OP_W-1:0] OP_RLC  = 5'd8;
  localparam logic [OP_W-1:0] OP_RRC  = 5'd9;
  localparam logic [OP_W-1:0] OP_RAL  = 5'd10;
  localparam logic [OP_W-1:0] OP_RAR  = 5'd11;
  localparam logic [OP_W-1:0] OP_DAA  = 5'd12;
  localparam logic [OP_W-1:0] OP_CMA  = 5'd13;
  localparam logic [OP_W-1:0] OP_STC  = 5'd14;
  localparam logic [OP_W-1:0] OP_CMC  = 5'd15;
  localparam logic [OP_W-1:0] OP_LOAD = 5'd16;

  // decimal adjust constants
  localparam logic [DATA_W-1:0] DAA_LO_ADD = 8'h06;
  localparam logic [DATA_W-1:0] DAA_HI_ADD = 8'h60;
  localparam logic [3:0]        BCD_MAX    = 4'h9;

  // flag register
  typedef struct packed {
    logic sign;
    logic zero;
    logic aux;
    logic parity;
    logic carry;
  } flags_t;

  // result transaction, accumulator in the low bits
  typedef struct packed {
    logic              carry;
    logic              parity;
    logic              aux;
    logic              zero;
    logic              sign;
    logic [DATA_W-1:0] acc;
  } result_t;

  localparam int unsigned RES_W   = $bits(result_t);
  localparam int unsigned TDATA_W = ((RES_W + 7) / 8) * 8;

endpackage
`default_nettype wire

FILE: hdl/accumulator_alu_with_flags.sv
// 8-bit accumulator alu with sign, zero, aux carry, parity and carry flags
// depends on aawf_pkg and accumulator_alu_with_flags_macros.svh
// each result is registered in the output register, or held in the skid
// register while the output is stalled; one transaction per cycle while
// out_tready is high; the accumulator and flag registers feed back through one
// add/logic stage, and the skid register takes one more transaction on a stall
// reset clears the accumulator, all flags and the valid bits of both output buffers
`default_nettype none
`include "accumulator_alu_with_flags_macros.svh"
module accumulator_alu_with_flags (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [4:0] opcode, [12:5] operand, [15:13] zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // [7:0] acc_out, [8] sign_flag, [9] zero_flag,
                                       // [10] aux_flag, [11] parity_flag,
                                       // [12] carry_flag, [15:13] zero
);

  localparam int unsigned DW = aawf_pkg::DATA_W;

  logic [aawf_pkg::OP_W-1:0] opcode;
  logic [DW-1:0]             operand;

  logic [DW-1:0]     acc_r;
  aawf_pkg::flags_t  flags_r;
  logic [DW-1:0]     acc_nxt;
  aawf_pkg::flags_t  flags_nxt;

  aawf_pkg::result_t out_data_r;
  aawf_pkg::result_t skid_data_r;
  aawf_pkg::result_t res_nxt;
  logic              out_valid_r;
  logic              skid_valid_r;

  logic in_acc;
  logic out_take;
  logic out_free;

  // alu intermediates
  logic          cin;
  logic [DW:0]   sum;
  logic [4:0]    nib_sum;
  logic [DW:0]   subtr;
  logic [DW-1:0] diff;
  logic          szp_upd;
  logic [DW-1:0] szp_val;
  logic          daa_lo;
  logic          daa_hi;
  logic [4:0]    daa_nib;
  logic [DW-1:0] daa_v1;
  logic [DW-1:0] daa_v2;

  assign opcode  = in_tdata[aawf_pkg::OP_W-1:0];
  assign operand = in_tdata[aawf_pkg::OP_W +: DW];

  // handshake
  assign in_tready = ~skid_valid_r;
  assign in_acc    = in_tvalid & in_tready;
  assign out_take  = out_valid_r & out_tready;
  assign out_free  = ~out_valid_r | out_take;

  // shared arithmetic
  always_comb begin
    cin     = ((opcode == aawf_pkg::OP_ADC) || (opcode == aawf_pkg::OP_SBB)) ?
              flags_r.carry : 1'b0;
    sum     = {1'b0, acc_r} + {1'b0, operand} + {{DW{1'b0}}, cin};
    nib_sum = {1'b0, acc_r[3:0]} + {1'b0, operand[3:0]};
    subtr   = {1'b0, operand} + {{DW{1'b0}}, cin};
    diff    = acc_r - subtr[DW-1:0];
    // decimal adjust
    daa_lo  = (acc_r[3:0] > aawf_pkg::BCD_MAX) | flags_r.aux;
    daa_nib = {1'b0, acc_r[3:0]} + {1'b0, aawf_pkg::DAA_LO_ADD[3:0]};
    daa_v1  = daa_lo ? (acc_r + aawf_pkg::DAA_LO_ADD) : acc_r;
    daa_hi  = (daa_v1[7:4] > aawf_pkg::BCD_MAX) | flags_r.carry;
    daa_v2  = daa_hi ? (daa_v1 + aawf_pkg::DAA_HI_ADD) : daa_v1;
  end

  // operation select
  always_comb begin
    acc_nxt   = acc_r;
    flags_nxt = flags_r;
    szp_upd   = 1'b0;
    szp_val   = acc_r;
    case (opcode)
      aawf_pkg::OP_ADD, aawf_pkg::OP_ADC: begin
        acc_nxt         = sum[DW-1:0];
        szp_upd         = 1'b1;
        szp_val         = sum[DW-1:0];
        flags_nxt.aux   = nib_sum[4];
        flags_nxt.carry = sum[DW];
      end
      aawf_pkg::OP_SUB, aawf_pkg::OP_SBB, aawf_pkg::OP_CMP: begin
        if (opcode != aawf_pkg::OP_CMP) begin
          acc_nxt = diff;
        end
        szp_upd         = 1'b1;
        szp_val         = diff;
        flags_nxt.aux   = acc_r[3:0] < operand[3:0];
        flags_nxt.carry = subtr > {1'b0, acc_r};
      end
      aawf_pkg::OP_AND: begin
        acc_nxt         = acc_r & operand;
        szp_upd         = 1'b1;
        szp_val         = acc_r & operand;
        flags_nxt.aux   = acc_r[3] | operand[3];
        flags_nxt.carry = 1'b0;
      end
      aawf_pkg::OP_XOR: begin
        acc_nxt         = acc_r ^ operand;
        szp_upd         = 1'b1;
        szp_val         = acc_r ^ operand;
        flags_nxt.aux   = 1'b0;
        flags_nxt.carry = 1'b0;
      end
      aawf_pkg::OP_OR: begin
        acc_nxt         = acc_r | operand;
        szp_upd         = 1'b1;
        szp_val         = acc_r | operand;
        flags_nxt.aux   = 1'b0;
        flags_nxt.carry = 1'b0;
      end
      aawf_pkg::OP_RLC: begin
        acc_nxt         = {acc_r[DW-2:0], acc_r[DW-1]};
        flags_nxt.carry = acc_r[DW-1];
      end
      aawf_pkg::OP_RRC: begin
        acc_nxt         = {acc_r[0], acc_r[DW-1:1]};
        flags_nxt.carry = acc_r[0];
      end
      aawf_pkg::OP_RAL: begin
        acc_nxt         = {acc_r[DW-2:0], flags_r.carry};
        flags_nxt.carry = acc_r[DW-1];
      end
      aawf_pkg::OP_RAR: begin
        acc_nxt         = {flags_r.carry, acc_r[DW-1:1]};
        flags_nxt.carry = acc_r[0];
      end
      aawf_pkg::OP_DAA: begin
        acc_nxt         = daa_v2;
        szp_upd         = 1'b1;
        szp_val         = daa_v2;
        flags_nxt.aux   = daa_lo & daa_nib[4];
        flags_nxt.carry = daa_hi;
      end
      aawf_pkg::OP_CMA: begin
        acc_nxt = ~acc_r;
      end
      aawf_pkg::OP_STC: begin
        flags_nxt.carry = 1'b1;
      end
      aawf_pkg::OP_CMC: begin
        flags_nxt.carry = ~flags_r.carry;
      end
      aawf_pkg::OP_LOAD: begin
        acc_nxt = operand;
      end
      default: begin
        acc_nxt = acc_r;
      end
    endcase
    // sign, zero and parity from the result
    if (szp_upd) begin
      flags_nxt.sign   = szp_val[DW-1];
      flags_nxt.zero   = (szp_val == '0);
      flags_nxt.parity = ~^szp_val;
    end
  end

  // result transaction
  always_comb begin
    res_nxt.acc    = acc_nxt;
    res_nxt.sign   = flags_nxt.sign;
    res_nxt.zero   = flags_nxt.zero;
    res_nxt.aux    = flags_nxt.aux;
    res_nxt.parity = flags_nxt.parity;
    res_nxt.carry  = flags_nxt.carry;
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      flags_r <= '0;
    end else if (in_acc) begin
      acc_r   <= acc_nxt;
      flags_r <= flags_nxt;
    end
  end

  // output register and skid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r | in_acc;
      skid_valid_r <= 1'b0;
    end else if (in_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= skid_valid_r ? skid_data_r : res_nxt;
    end else if (in_acc) begin
      skid_data_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(aawf_pkg::TDATA_W - aawf_pkg::RES_W){1'b0}}, out_data_r};

  // checks
  `AAWF_ASSERT_IMP(a_skid_needs_out, skid_valid_r, out_valid_r)
  `AAWF_ASSERT_NXT(a_accept_shows, in_acc, out_valid_r)
  `AAWF_ASSERT_NXT(a_direct_matches_state, in_acc && out_free, out_data_r.acc == acc_r)
  `AAWF_ASSERT_NXT(a_cmp_keeps_acc, in_acc && (opcode == aawf_pkg::OP_CMP), acc_r == $past(acc_r))
  `AAWF_ASSERT_NXT(a_logic_clears_carry, in_acc && ((opcode == aawf_pkg::OP_XOR) || (opcode == aawf_pkg::OP_OR)), !flags_r.carry && !flags_r.aux)

endmodule
`default_nettype wire

FILE: dv/accumulator_alu_with_flags_test.sv
// self-checking testbench for the 8-bit accumulator alu with flags
// depends on aawf_pkg and the accumulator_alu_with_flags rtl, which includes accumulator_alu_with_flags_macros.svh
// a scoreboard class predicts accumulator and flags per input transaction and checks results
module accumulator_alu_with_flags_test;

  localparam int unsigned ITEMS_PER_PHASE = 382;
  localparam int unsigned STALL_LIMIT     = 1000;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam logic [aawf_pkg::OP_W-1:0] OP_LAST_UNUSED  = 5'd31;
  localparam logic [aawf_pkg::OP_W-1:0] OP_FIRST_UNUSED = 5'd17;

  // predicts the alu state and holds the results still owed by the dut
  class alu_flag_scoreboard;
    logic [aawf_pkg::DATA_W-1:0] acc_q;
    aawf_pkg::flags_t            flag_q;
    aawf_pkg::result_t           owed_results[$];
    int unsigned                 errors;

    function new();
      acc_q  = '0;
      flag_q = '0;
      errors = 0;
    endfunction

    function void set_szp(logic [aawf_pkg::DATA_W-1:0] r);
      flag_q.sign   = r[7];
      flag_q.zero   = (r == '0);
      flag_q.parity = ~^r;
    endfunction

    // apply one operation to the predicted state, return the reported values
    function aawf_pkg::result_t execute_op(logic [aawf_pkg::OP_W-1:0] op,
                                           logic [aawf_pkg::DATA_W-1:0] operand);
      logic [aawf_pkg::DATA_W-1:0] a;
      logic [aawf_pkg::DATA_W-1:0] r;
      logic [aawf_pkg::DATA_W:0]   wide;
      logic [4:0]                  nib_sum;
      logic                        cin;
      aawf_pkg::result_t           res;
      a   = acc_q;
      cin = 1'b0;
      case (op)
        aawf_pkg::OP_ADD, aawf_pkg::OP_ADC: begin
          if (op == aawf_pkg::OP_ADC) cin = flag_q.carry;
          wide = {1'b0, a} + {1'b0, operand} + {{aawf_pkg::DATA_W{1'b0}}, cin};
          r = wide[aawf_pkg::DATA_W-1:0];
          set_szp(r);
          // aux ignores the carry-in
          nib_sum = {1'b0, a[3:0]} + {1'b0, operand[3:0]};
          flag_q.aux   = nib_sum[4];
          flag_q.carry = wide[aawf_pkg::DATA_W];
          acc_q = r;
        end
        aawf_pkg::OP_SUB, aawf_pkg::OP_SBB, aawf_pkg::OP_CMP: begin
          if (op == aawf_pkg::OP_SBB) cin = flag_q.carry;
          wide = {1'b0, operand} + {{aawf_pkg::DATA_W{1'b0}}, cin};
          r = a - wide[aawf_pkg::DATA_W-1:0];
          set_szp(r);
          flag_q.aux   = (a[3:0] < operand[3:0]);
          flag_q.carry = (wide > {1'b0, a});
          if (op != aawf_pkg::OP_CMP) acc_q = r;
        end
        aawf_pkg::OP_AND, aawf_pkg::OP_XOR, aawf_pkg::OP_OR: begin
          if (op == aawf_pkg::OP_AND) r = a & operand;
          else if (op == aawf_pkg::OP_XOR) r = a ^ operand;
          else r = a | operand;
          set_szp(r);
          flag_q.carry = 1'b0;
          flag_q.aux   = (op == aawf_pkg::OP_AND) ? (a[3] | operand[3]) : 1'b0;
          acc_q = r;
        end
        aawf_pkg::OP_RLC: begin
          acc_q = {a[6:0], a[7]};
          flag_q.carry = a[7];
        end
        aawf_pkg::OP_RRC: begin
          acc_q = {a[0], a[7:1]};
          flag_q.carry = a[0];
        end
        aawf_pkg::OP_RAL: begin
          acc_q = {a[6:0], flag_q.carry};
          flag_q.carry = a[7];
        end
        aawf_pkg::OP_RAR: begin
          acc_q = {flag_q.carry, a[7:1]};
          flag_q.carry = a[0];
        end
        aawf_pkg::OP_DAA: begin
          cin = flag_q.carry;
          r = a;
          // low digit correction, aux is the nibble carry of that add
          if (r[3:0] > aawf_pkg::BCD_MAX || flag_q.aux) begin
            nib_sum = {1'b0, r[3:0]} + {1'b0, aawf_pkg::DAA_LO_ADD[3:0]};
            flag_q.aux = nib_sum[4];
            r = r + aawf_pkg::DAA_LO_ADD;
          end else begin
            flag_q.aux = 1'b0;
          end
          // high digit correction looks at the updated value
          if (r[7:4] > aawf_pkg::BCD_MAX || cin) begin
            r = r + aawf_pkg::DAA_HI_ADD;
            flag_q.carry = 1'b1;
          end else begin
            flag_q.carry = 1'b0;
          end
          set_szp(r);
          acc_q = r;
        end
        aawf_pkg::OP_CMA:  acc_q = ~a;
        aawf_pkg::OP_STC:  flag_q.carry = 1'b1;
        aawf_pkg::OP_CMC:  flag_q.carry = ~flag_q.carry;
        aawf_pkg::OP_LOAD: acc_q = operand;
        default: ;
      endcase
      res.acc    = acc_q;
      res.sign   = flag_q.sign;
      res.zero   = flag_q.zero;
      res.aux    = flag_q.aux;
      res.parity = flag_q.parity;
      res.carry  = flag_q.carry;
      return res;
    endfunction

    function void note_accepted(logic [aawf_pkg::OP_W-1:0] op,
                                logic [aawf_pkg::DATA_W-1:0] operand);
      owed_results.push_back(execute_op(op, operand));
    endfunction

    function void compare_field(string name, logic [aawf_pkg::DATA_W-1:0] want,
                                logic [aawf_pkg::DATA_W-1:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%02h, actual 0x%02h", $time, name, want, got);
      end
    endfunction

    function void compare_flag(string name, logic want, logic got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, want, got);
      end
    endfunction

    // out_tdata: [7:0] acc, [8] sign, [9] zero, [10] aux, [11] parity, [12] carry
    function void check_result(logic [15:0] tdata);
      aawf_pkg::result_t want;
      if (owed_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transaction, expected none, actual 0x%04h",
                 $time, tdata);
        return;
      end
      want = owed_results.pop_front();
      compare_field("acc_out",    want.acc,    tdata[7:0]);
      compare_flag("sign_flag",   want.sign,   tdata[8]);
      compare_flag("zero_flag",   want.zero,   tdata[9]);
      compare_flag("aux_flag",    want.aux,    tdata[10]);
      compare_flag("parity_flag", want.parity, tdata[11]);
      compare_flag("carry_flag",  want.carry,  tdata[12]);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned quiet_cycles = 0;
  alu_flag_scoreboard alu_sb = new();

  accumulator_alu_with_flags dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  // receiver back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) alu_sb.check_result(out_tdata);
  end

  // cycles without any transaction on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  // one input transaction, with random idle cycles ahead of it
  task automatic send_item(logic [aawf_pkg::OP_W-1:0] op,
                           logic [aawf_pkg::DATA_W-1:0] operand);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, operand, op};
    do @(posedge clk); while (!in_tready);
    alu_sb.note_accepted(op, operand);
  endtask

  function automatic logic [aawf_pkg::DATA_W-1:0] random_operand();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return {4'($urandom_range(0, 15)), 4'hF};
      3:       return 8'h80;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [aawf_pkg::DATA_W-1:0] random_bcd();
    return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
  endfunction

  // decimal arithmetic: load, add or subtract a bcd byte, then adjust
  task automatic send_bcd_sequence();
    logic [aawf_pkg::OP_W-1:0] arith_op;
    case ($urandom_range(0, 3))
      0:       arith_op = aawf_pkg::OP_ADD;
      1:       arith_op = aawf_pkg::OP_ADC;
      2:       arith_op = aawf_pkg::OP_SUB;
      default: arith_op = aawf_pkg::OP_SBB;
    endcase
    send_item(aawf_pkg::OP_LOAD, random_bcd());
    send_item(arith_op, random_bcd());
    send_item(aawf_pkg::OP_DAA, random_operand());
  endtask

  task automatic run_random_phase(int unsigned idle_pct, int unsigned stall);
    int unsigned sent;
    sent = 0;
    send_idle_pct = idle_pct;
    stall_pct = stall;
    while (sent < ITEMS_PER_PHASE) begin
      if ($urandom_range(0, 9) < 3) begin
        send_bcd_sequence();
        sent += 3;
      end else begin
        if ($urandom_range(0, 19) == 0)
          send_item(5'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED)), random_operand());
        else
          send_item(5'($urandom_range(aawf_pkg::OP_ADD, aawf_pkg::OP_LOAD)),
                    random_operand());
        sent++;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset state, extremes and each flag rule
    send_item(OP_LAST_UNUSED, 8'hFF);
    send_item(aawf_pkg::OP_LOAD, 8'hFF);
    send_item(aawf_pkg::OP_ADD, 8'h01);
    send_item(aawf_pkg::OP_ADC, 8'h00);
    send_item(aawf_pkg::OP_SUB, 8'h02);
    send_item(aawf_pkg::OP_SBB, 8'hFF);
    send_item(aawf_pkg::OP_LOAD, 8'h80);
    send_item(aawf_pkg::OP_CMP, 8'h80);
    send_item(aawf_pkg::OP_AND, 8'h08);
    send_item(aawf_pkg::OP_LOAD, 8'h5A);
    send_item(aawf_pkg::OP_XOR, 8'hFF);
    send_item(aawf_pkg::OP_OR, 8'h00);
    send_item(aawf_pkg::OP_RLC, 8'h00);
    send_item(aawf_pkg::OP_RRC, 8'hFF);
    send_item(aawf_pkg::OP_STC, 8'h00);
    send_item(aawf_pkg::OP_RAL, 8'h00);
    send_item(aawf_pkg::OP_RAR, 8'h00);
    send_item(aawf_pkg::OP_CMC, 8'h00);
    send_item(aawf_pkg::OP_LOAD, 8'h9B);
    send_item(aawf_pkg::OP_DAA, 8'h00);
    send_item(aawf_pkg::OP_LOAD, 8'h09);
    send_item(aawf_pkg::OP_ADD, 8'h09);
    send_item(aawf_pkg::OP_DAA, 8'h00);
    send_item(aawf_pkg::OP_STC, 8'h00);
    send_item(aawf_pkg::OP_LOAD, 8'h11);
    send_item(aawf_pkg::OP_DAA, 8'h00);
    send_item(aawf_pkg::OP_CMA, 8'h00);
    send_item(OP_FIRST_UNUSED, 8'h00);

    run_random_phase(0, 0);
    run_random_phase(56, 0);
    run_random_phase(0, 56);
    run_random_phase(22, 22);
    in_tvalid <= 1'b0;

    // drain the remaining results, then watch for strays
    while (alu_sb.owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (alu_sb.errors == 0 && alu_sb.owed_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
